@@ sv/terq_pkg.sv @@
// Package for the timed event release queue: field widths, mode codes,
// controller state and pass types, and the command/status structs.
// No dependencies.
package terq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int MAX_OUT       = 16;
    localparam int REL_CNT_W     = $clog2(MAX_OUT + 1);

    localparam int MODE_W     = 3;
    localparam int ID_W       = 16;
    localparam int FIELD_TM_W = 32;
    localparam int NT_W       = 33;

    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_NEXT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PROCESS  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIRE_ALL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_PROMOTE,
        S_SCAN,
        S_REMOVE,
        S_CLEAR,
        S_EMIT,
        S_EMIT_REL
    } t_state;

    typedef enum logic [1:0] {
        PASS_SCAN,
        PASS_PROMOTE,
        PASS_REMOVE,
        PASS_CLEAR
    } t_pass;

    typedef struct packed {
        logic  load;
        logic  add;
        logic  start;
        t_pass kind;
        logic  step;
        logic  emit;
        logic  emit_rel;
        logic  emit_last;
    } t_cmd;

    typedef struct packed {
        logic pass_done;
        logic due;
        logic more_ok;
        logic out_free;
    } t_stat;

endpackage

@@ sv/timed_event_release_queue.sv @@
// Top level of the timed event release queue: controller plus datapath.
// Depends on terq_pkg, terq_ctrl and terq_datapath.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   add, add for next round, process due, fire all, clear or query.
// - Output channel (o_out_valid / i_out_stall) carries result items; o_last
//   marks the final result of each command.
// - Entries sit in a ring of CAPACITY slots that rotates one slot per cycle
//   while a pass runs; the passes over the n occupied entries are where the
//   time goes.
// - Add and query: an add goes through S_ADD and then S_EMIT, a query goes
//   straight to S_EMIT, which loads the result register. Clear: one pass.
// - Process and fire all: a promotion pass and a search pass, then per
//   released event one removal pass that also finds the next earliest
//   entry, at most sixteen releases per command.
// - One command is worked at a time; o_in_stall stays high until the last
//   result has been loaded into the output register, which then holds while
//   the receiver stalls and the next command can already be taken.
// - Synchronous reset empties the store and drops any pending result.
module timed_event_release_queue #(
    parameter int CAPACITY  = terq_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = terq_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [terq_pkg::MODE_W-1:0]       i_mode,
    input  logic [terq_pkg::ID_W-1:0]         i_event_id,
    input  logic [terq_pkg::FIELD_TM_W-1:0]   i_event_time,
    input  logic [terq_pkg::FIELD_TM_W-1:0]   i_current_time,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [terq_pkg::ID_W-1:0]         o_released_id,
    output logic                              o_released,
    output logic                              o_last,
    output logic                              o_rejected,
    output logic                              o_is_empty,
    output logic signed [terq_pkg::NT_W-1:0]  o_next_timeout
);

    terq_pkg::t_cmd  w_cmd;
    terq_pkg::t_stat w_stat;

    // sequence the passes
    terq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // hold the entries and the result register
    terq_datapath #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_mode         (i_mode),
        .i_event_id     (i_event_id),
        .i_event_time   (i_event_time),
        .i_current_time (i_current_time),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_released_id  (o_released_id),
        .o_released     (o_released),
        .o_last         (o_last),
        .o_rejected     (o_rejected),
        .o_is_empty     (o_is_empty),
        .o_next_timeout (o_next_timeout)
    );

endmodule

@@ sv/terq_ctrl.sv @@
// Sequencing controller for the timed event release queue.
// Depends on terq_pkg (state, pass kind, command and status types).
module terq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [terq_pkg::MODE_W-1:0] i_mode,
    input  terq_pkg::t_stat            i_stat,
    output logic                       o_in_stall,
    output terq_pkg::t_cmd             o_cmd
);

    terq_pkg::t_state r_state;
    terq_pkg::t_state n_state;
    logic             w_again;

    assign w_again = i_stat.due && i_stat.more_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= terq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            terq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        terq_pkg::MODE_ADD, terq_pkg::MODE_ADD_NEXT: n_state = terq_pkg::S_ADD;
                        terq_pkg::MODE_PROCESS, terq_pkg::MODE_FIRE_ALL: begin
                            n_state = terq_pkg::S_PROMOTE;
                        end
                        terq_pkg::MODE_CLEAR: n_state = terq_pkg::S_CLEAR;
                        default: n_state = terq_pkg::S_EMIT;
                    endcase
                end
            end
            terq_pkg::S_ADD: n_state = terq_pkg::S_EMIT;
            terq_pkg::S_PROMOTE: begin
                if (i_stat.pass_done) n_state = terq_pkg::S_SCAN;
            end
            terq_pkg::S_SCAN: begin
                if (i_stat.pass_done) begin
                    n_state = i_stat.due ? terq_pkg::S_REMOVE : terq_pkg::S_EMIT;
                end
            end
            terq_pkg::S_REMOVE: begin
                if (i_stat.pass_done) n_state = terq_pkg::S_EMIT_REL;
            end
            terq_pkg::S_CLEAR: begin
                if (i_stat.pass_done) n_state = terq_pkg::S_EMIT;
            end
            terq_pkg::S_EMIT: begin
                if (i_stat.out_free) n_state = terq_pkg::S_IDLE;
            end
            terq_pkg::S_EMIT_REL: begin
                if (i_stat.out_free) begin
                    n_state = w_again ? terq_pkg::S_REMOVE : terq_pkg::S_IDLE;
                end
            end
            default: n_state = terq_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = terq_pkg::PASS_SCAN;
        o_in_stall = 1'b1;
        case (r_state)
            terq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    case (i_mode)
                        terq_pkg::MODE_PROCESS, terq_pkg::MODE_FIRE_ALL: begin
                            o_cmd.start = 1'b1;
                            o_cmd.kind  = terq_pkg::PASS_PROMOTE;
                        end
                        terq_pkg::MODE_CLEAR: begin
                            o_cmd.start = 1'b1;
                            o_cmd.kind  = terq_pkg::PASS_CLEAR;
                        end
                        default: o_cmd.start = 1'b0;
                    endcase
                end
            end
            terq_pkg::S_ADD: o_cmd.add = 1'b1;
            terq_pkg::S_PROMOTE: begin
                o_cmd.step = !i_stat.pass_done;
                if (i_stat.pass_done) begin
                    o_cmd.start = 1'b1;
                    o_cmd.kind  = terq_pkg::PASS_SCAN;
                end
            end
            terq_pkg::S_SCAN: begin
                o_cmd.step = !i_stat.pass_done;
                if (i_stat.pass_done && i_stat.due) begin
                    o_cmd.start = 1'b1;
                    o_cmd.kind  = terq_pkg::PASS_REMOVE;
                end
            end
            terq_pkg::S_REMOVE, terq_pkg::S_CLEAR: o_cmd.step = !i_stat.pass_done;
            terq_pkg::S_EMIT: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_last = 1'b1;
            end
            terq_pkg::S_EMIT_REL: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_rel  = 1'b1;
                o_cmd.emit_last = !w_again;
                if (i_stat.out_free && w_again) begin
                    o_cmd.start = 1'b1;
                    o_cmd.kind  = terq_pkg::PASS_REMOVE;
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

@@ sv/terq_datapath.sv @@
// Datapath of the timed event release queue: the entry ring, the pass
// step logic, earliest-entry tracking and the result register.
// Depends on terq_pkg (widths, mode codes, command and status types).
module terq_datapath #(
    parameter int CAPACITY  = terq_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = terq_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  terq_pkg::t_cmd                    i_cmd,
    output terq_pkg::t_stat                   o_stat,
    input  logic [terq_pkg::MODE_W-1:0]       i_mode,
    input  logic [terq_pkg::ID_W-1:0]         i_event_id,
    input  logic [terq_pkg::FIELD_TM_W-1:0]   i_event_time,
    input  logic [terq_pkg::FIELD_TM_W-1:0]   i_current_time,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [terq_pkg::ID_W-1:0]         o_released_id,
    output logic                              o_released,
    output logic                              o_last,
    output logic                              o_rejected,
    output logic                              o_is_empty,
    output logic signed [terq_pkg::NT_W-1:0]  o_next_timeout
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DIFF_W = (TIME_BITS + 1 > terq_pkg::NT_W) ? TIME_BITS + 1 : terq_pkg::NT_W;

    typedef struct packed {
        logic                      stg;
        logic [TIME_BITS-1:0]      tm;
        logic [terq_pkg::ID_W-1:0] id;
    } t_entry;

    t_entry r_slot [CAPACITY];
    t_entry n_slot [CAPACITY];

    logic [CNT_W-1:0]               r_cnt;
    logic [CNT_W-1:0]               r_n0;
    logic [CNT_W-1:0]               r_step;
    logic [CNT_W-1:0]               r_s;
    logic [CNT_W-1:0]               r_kept;
    logic [IDX_W-1:0]               r_rm_idx;
    terq_pkg::t_pass                r_kind;
    logic                           r_min_vld;
    logic [TIME_BITS-1:0]           r_min_time;
    logic [IDX_W-1:0]               r_min_idx;
    logic [terq_pkg::MODE_W-1:0]    r_mode;
    logic [terq_pkg::ID_W-1:0]      r_id;
    logic [TIME_BITS-1:0]           r_etime;
    logic [TIME_BITS-1:0]           r_cur;
    logic                           r_rej;
    logic [terq_pkg::REL_CNT_W-1:0] r_k;
    logic [terq_pkg::ID_W-1:0]      r_rel_id;

    logic                           r_out_valid;
    logic [terq_pkg::ID_W-1:0]      r_out_id;
    logic                           r_out_rel;
    logic                           r_out_last;
    logic                           r_out_rej;
    logic                           r_out_empty;
    logic signed [terq_pkg::NT_W-1:0] r_out_nt;

    logic             w_full;
    logic             w_push;
    logic             w_step;
    logic             w_pop;
    logic             w_promote;
    logic [CNT_W-1:0] w_bound;
    t_entry           w_head;
    t_entry           w_head_ins;
    t_entry           w_new;
    logic             w_keep_live;
    logic [DIFF_W-1:0] w_diff;

    assign w_full    = (r_cnt == CNT_W'(CAPACITY));
    assign w_push    = i_cmd.add && !w_full;
    assign w_step    = i_cmd.step && (r_step != r_n0);
    assign w_promote = (r_kind == terq_pkg::PASS_PROMOTE);
    assign w_head    = r_slot[0];

    // drop the head when it is the chosen entry of a removal, or live during a clear
    assign w_pop = ((r_kind == terq_pkg::PASS_REMOVE) && (r_step == CNT_W'(r_rm_idx)))
                || ((r_kind == terq_pkg::PASS_CLEAR) && !w_head.stg);

    // live heads of a promotion go in front of the staged block at the tail
    assign w_bound = (w_promote && !w_head.stg) ? (r_cnt - r_s) : r_cnt;

    always_comb begin
        w_head_ins = w_head;
        if (w_promote) w_head_ins.stg = 1'b0;
    end

    assign w_keep_live = !w_promote && !w_head.stg;

    always_comb begin
        w_new.stg = (r_mode == terq_pkg::MODE_ADD_NEXT);
        w_new.tm  = r_etime;
        w_new.id  = r_id;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        t_entry w_up;
        if (g < CAPACITY - 1) begin : g_mid
            assign w_up = r_slot[g + 1];
        end else begin : g_end
            assign w_up = r_slot[g];
        end
        always_comb begin
            n_slot[g] = r_slot[g];
            if (w_push && (r_cnt == CNT_W'(g))) begin
                n_slot[g] = w_new;
            end else if (w_step) begin
                if (w_pop || (CNT_W'(g + 1) < w_bound)) begin
                    n_slot[g] = w_up;
                end else if (CNT_W'(g + 1) == w_bound) begin
                    n_slot[g] = w_head_ins;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign w_diff = DIFF_W'(r_min_time) - DIFF_W'(r_cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_n0        <= '0;
            r_step      <= '0;
            r_s         <= '0;
            r_kept      <= '0;
            r_kind      <= terq_pkg::PASS_SCAN;
            r_min_vld   <= 1'b0;
            r_rej       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rej <= 1'b0;
                r_k   <= '0;
            end
            if (i_cmd.add) begin
                if (w_full) begin
                    r_rej <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    if (!w_new.stg && (!r_min_vld || (w_new.tm < r_min_time))) begin
                        r_min_vld <= 1'b1;
                        r_min_idx <= r_cnt[IDX_W-1:0];
                    end
                end
            end
            if (i_cmd.start) begin
                r_step    <= '0;
                r_n0      <= r_cnt;
                r_s       <= '0;
                r_kept    <= '0;
                r_kind    <= i_cmd.kind;
                r_rm_idx  <= r_min_idx;
                r_min_vld <= 1'b0;
            end else if (w_step) begin
                r_step <= r_step + 1'b1;
                if (w_pop) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_kind == terq_pkg::PASS_REMOVE) r_rel_id <= w_head.id;
                end else begin
                    r_kept <= r_kept + 1'b1;
                    if (w_promote && w_head.stg) r_s <= r_s + 1'b1;
                    // strict compare keeps the first of equal times
                    if (w_keep_live && (!r_min_vld || (w_head.tm < r_min_time))) begin
                        r_min_vld <= 1'b1;
                        r_min_idx <= r_kept[IDX_W-1:0];
                    end
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (i_cmd.emit_rel) r_k <= r_k + 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input item and result payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_id    <= i_event_id;
            r_etime <= TIME_BITS'(i_event_time);
            r_cur   <= TIME_BITS'(i_current_time);
        end
        if (i_cmd.add && !w_full && !w_new.stg && (!r_min_vld || (w_new.tm < r_min_time))) begin
            r_min_time <= w_new.tm;
        end else if (!i_cmd.start && w_step && !w_pop && w_keep_live
                     && (!r_min_vld || (w_head.tm < r_min_time))) begin
            r_min_time <= w_head.tm;
        end
        if (i_cmd.emit) begin
            r_out_id    <= i_cmd.emit_rel ? r_rel_id : '0;
            r_out_rel   <= i_cmd.emit_rel;
            r_out_last  <= i_cmd.emit_last;
            r_out_rej   <= r_rej;
            r_out_empty <= !r_min_vld;
            r_out_nt    <= r_min_vld ? signed'(w_diff[terq_pkg::NT_W-1:0]) : '0;
        end
    end

    assign o_stat.pass_done = (r_step == r_n0);
    assign o_stat.due       = r_min_vld
                           && ((r_mode == terq_pkg::MODE_FIRE_ALL) || (r_min_time <= r_cur));
    assign o_stat.more_ok   = (r_k < terq_pkg::REL_CNT_W'(terq_pkg::MAX_OUT - 1));
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_released_id  = r_out_id;
    assign o_released     = r_out_rel;
    assign o_last         = r_out_last;
    assign o_rejected     = r_out_rej;
    assign o_is_empty     = r_out_empty;
    assign o_next_timeout = r_out_nt;

endmodule

@@ sv/terq_checker.sv @@
// Port-level checks for the timed event release queue, bound to the top.
// Depends on terq_pkg and timed_event_release_queue.
module terq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [terq_pkg::ID_W-1:0]         o_released_id,
    input logic                              o_released,
    input logic                              o_last,
    input logic                              o_rejected,
    input logic                              o_is_empty,
    input logic signed [terq_pkg::NT_W-1:0]  o_next_timeout
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_released_id) && $stable(o_last))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second command taken while one is in work");

    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_released |-> o_last)
        else $error("non-release result not marked last");

    a_empty_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_next_timeout == '0)
        else $error("empty store with non-zero timeout");

    a_rel_not_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_released |-> !o_rejected)
        else $error("released result flagged as rejected");

endmodule

bind timed_event_release_queue terq_checker u_terq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_released_id  (o_released_id),
    .o_released     (o_released),
    .o_last         (o_last),
    .o_rejected     (o_rejected),
    .o_is_empty     (o_is_empty),
    .o_next_timeout (o_next_timeout)
);

@@ dv/timed_event_release_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for timed_event_release_queue: directed table, then random rounds
// of adds closed by a process, fire all, clear or query. Depends on terq_pkg and on that module.
module timed_event_release_queue_tb;

    localparam int SLOTS       = terq_pkg::CAPACITY_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 40;

    // Codes that the block decodes as a query.
    localparam logic [terq_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [terq_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;

    typedef struct packed {
        logic [terq_pkg::ID_W-1:0] rid;
        logic                      rel;
        logic                      last;
        logic                      rej;
        logic                      empty;
        logic [terq_pkg::NT_W-1:0] nt;
    } t_result;

    // One row of the directed table: rep transfers, id advancing by one and the
    // event time by tstep per transfer. Typed rows carry their own expectation.
    typedef struct packed {
        logic [terq_pkg::MODE_W-1:0]     mode;
        logic [terq_pkg::ID_W-1:0]       id;
        logic [terq_pkg::FIELD_TM_W-1:0] etime;
        logic [terq_pkg::FIELD_TM_W-1:0] ctime;
        logic [4:0]                      rep;
        logic signed [15:0]              tstep;
        logic                            typed;
        t_result                         want;
    } t_row;

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             i_in_valid     = 1'b0;
    logic [terq_pkg::MODE_W-1:0]      i_mode         = terq_pkg::MODE_QUERY;
    logic [terq_pkg::ID_W-1:0]        i_event_id     = '0;
    logic [terq_pkg::FIELD_TM_W-1:0]  i_event_time   = '0;
    logic [terq_pkg::FIELD_TM_W-1:0]  i_current_time = '0;
    logic                             i_out_stall    = 1'b0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    logic [terq_pkg::ID_W-1:0]        o_released_id;
    logic                             o_released;
    logic                             o_last;
    logic                             o_rejected;
    logic                             o_is_empty;
    logic signed [terq_pkg::NT_W-1:0] o_next_timeout;

    timed_event_release_queue i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_event_id     (i_event_id),
        .i_event_time   (i_event_time),
        .i_current_time (i_current_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_released_id  (o_released_id),
        .o_released     (o_released),
        .o_last         (o_last),
        .o_rejected     (o_rejected),
        .o_is_empty     (o_is_empty),
        .o_next_timeout (o_next_timeout)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow store: slots 0 .. slot_used-1 are occupied, in arrival order.
    // ------------------------------------------------------------------
    logic [terq_pkg::FIELD_TM_W-1:0] slot_time   [SLOTS];
    logic [terq_pkg::ID_W-1:0]       slot_id     [SLOTS];
    bit                              slot_staged [SLOTS];
    int                              slot_used = 0;

    t_result step_out[$];          // results of the command just transferred
    t_result awaited_results[$];   // results still owed by the block
    t_row    dir_plan[$];
    t_result head;

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int releases_seen = 0;
    int rejects_seen  = 0;
    int quiet_cycles  = 0;
    int in_idle_pct   = 21;
    int out_idle_pct  = 77;

    // Append to the tail of each queue.
    function automatic void add_step_result(t_result r);
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void owe_result(t_result r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    function automatic void add_row(t_row r);
        dir_plan.insert(dir_plan.size(), r);
    endfunction

    // Earliest live slot, first one on equal times; -1 when none is live.
    function automatic int earliest_live();
        int best;
        int i;
        best = -1;
        for (i = 0; i < slot_used; i++) begin
            if (!slot_staged[i] && (best < 0 || slot_time[i] < slot_time[best]))
                best = i;
        end
        return best;
    endfunction

    // Status as seen after the step: empty flag and time to the earliest live event.
    function automatic t_result snapshot(logic [terq_pkg::ID_W-1:0] rid, logic rel, logic rej,
                                         logic [terq_pkg::FIELD_TM_W-1:0] cur);
        t_result r;
        int      e;
        e       = earliest_live();
        r.rid   = rel ? rid : '0;
        r.rel   = rel;
        r.last  = 1'b0;
        r.rej   = rej;
        r.empty = (e < 0);
        r.nt    = (e < 0) ? '0 : ({1'b0, slot_time[e]} - {1'b0, cur});
        return r;
    endfunction

    function automatic void drop_slot(int idx);
        int i;
        for (i = idx; i + 1 < slot_used; i++) begin
            slot_time[i]   = slot_time[i + 1];
            slot_id[i]     = slot_id[i + 1];
            slot_staged[i] = slot_staged[i + 1];
        end
        slot_used--;
        slot_staged[slot_used] = 1'b0;
    endfunction

    // Move staged slots behind the live ones, order kept, and make them live.
    function automatic void promote_staged();
        logic [terq_pkg::FIELD_TM_W-1:0] t [SLOTS];
        logic [terq_pkg::ID_W-1:0]       d [SLOTS];
        int                              n;
        int                              i;
        int                              pass;
        n = 0;
        for (pass = 0; pass < 2; pass++) begin
            for (i = 0; i < slot_used; i++) begin
                if (int'(slot_staged[i]) == pass) begin
                    t[n] = slot_time[i];
                    d[n] = slot_id[i];
                    n++;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            slot_time[i]   = t[i];
            slot_id[i]     = d[i];
            slot_staged[i] = 1'b0;
        end
    endfunction

    // Apply one command to the shadow store and leave its results in step_out.
    function automatic void release_step(logic [terq_pkg::MODE_W-1:0] mode,
                                         logic [terq_pkg::ID_W-1:0] id,
                                         logic [terq_pkg::FIELD_TM_W-1:0] et,
                                         logic [terq_pkg::FIELD_TM_W-1:0] cur);
        bit rej;
        bit done;
        int e;
        int i;
        logic [terq_pkg::ID_W-1:0] rid;
        step_out.delete();
        case (mode)
            terq_pkg::MODE_ADD, terq_pkg::MODE_ADD_NEXT: begin
                rej = (slot_used >= SLOTS);
                if (!rej) begin
                    slot_time[slot_used]   = et;
                    slot_id[slot_used]     = id;
                    slot_staged[slot_used] = (mode == terq_pkg::MODE_ADD_NEXT);
                    slot_used++;
                end
                add_step_result(snapshot('0, 1'b0, rej, cur));
            end
            terq_pkg::MODE_PROCESS, terq_pkg::MODE_FIRE_ALL: begin
                promote_staged();
                done = 1'b0;
                while (!done && step_out.size() < terq_pkg::MAX_OUT) begin
                    e = earliest_live();
                    if (e < 0 || (mode == terq_pkg::MODE_PROCESS && slot_time[e] > cur)) begin
                        done = 1'b1;
                    end else begin
                        rid = slot_id[e];
                        drop_slot(e);
                        add_step_result(snapshot(rid, 1'b1, 1'b0, cur));
                    end
                end
                if (step_out.size() == 0)
                    add_step_result(snapshot('0, 1'b0, 1'b0, cur));
            end
            default: begin
                // Clear takes live slots only; staged ones wait for the next round.
                if (mode == terq_pkg::MODE_CLEAR) begin
                    i = 0;
                    while (i < slot_used) begin
                        if (!slot_staged[i])
                            drop_slot(i);
                        else
                            i++;
                    end
                end
                add_step_result(snapshot('0, 1'b0, 1'b0, cur));
            end
        endcase
        step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side: optional idle gap, then hold the transfer until taken.
    // ------------------------------------------------------------------
    task automatic send_command(input logic [terq_pkg::MODE_W-1:0] mode,
                                input logic [terq_pkg::ID_W-1:0] id,
                                input logic [terq_pkg::FIELD_TM_W-1:0] et,
                                input logic [terq_pkg::FIELD_TM_W-1:0] cur,
                                input bit typed, input t_result want);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_event_id     <= id;
        i_event_time   <= et;
        i_current_time <= cur;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        release_step(mode, id, et, cur);
        if (typed)
            owe_result(want);
        else
            foreach (step_out[j])
                owe_result(step_out[j]);
        items_sent++;
    endtask

    // Drop valid and hold off until the block has delivered everything owed.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_row plan_row(logic [terq_pkg::MODE_W-1:0] mode,
                                      logic [terq_pkg::ID_W-1:0] id,
                                      logic [terq_pkg::FIELD_TM_W-1:0] et,
                                      logic [terq_pkg::FIELD_TM_W-1:0] cur,
                                      int rep, int tstep);
        t_row r;
        r       = '0;
        r.mode  = mode;
        r.id    = id;
        r.etime = et;
        r.ctime = cur;
        r.rep   = 5'(rep);
        r.tstep = 16'(tstep);
        return r;
    endfunction

    // Single transfer whose one result can be read straight off the inputs.
    function automatic t_row typed_row(logic [terq_pkg::MODE_W-1:0] mode,
                                       logic [terq_pkg::ID_W-1:0] id,
                                       logic [terq_pkg::FIELD_TM_W-1:0] et,
                                       logic [terq_pkg::FIELD_TM_W-1:0] cur,
                                       logic rej, logic empty,
                                       logic [terq_pkg::NT_W-1:0] nt);
        t_row r;
        r            = plan_row(mode, id, et, cur, 1, 0);
        r.typed      = 1'b1;
        r.want.last  = 1'b1;
        r.want.rej   = rej;
        r.want.empty = empty;
        r.want.nt    = nt;
        return r;
    endfunction

    // A burst of adds around one point in time, closed by a process, fire all,
    // clear or query; the rest is noise with fully random fields.
    task automatic random_round();
        logic [terq_pkg::FIELD_TM_W-1:0] now;
        logic [terq_pkg::FIELD_TM_W-1:0] et;
        logic [terq_pkg::MODE_W-1:0]     m;
        int                              n;
        int                              pick;
        int                              k;
        now = $urandom;
        if ($urandom_range(0, 99) < 80) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
                m  = ($urandom_range(0, 3) == 0) ? terq_pkg::MODE_ADD_NEXT
                                                 : terq_pkg::MODE_ADD;
                et = ($urandom_range(0, 9) == 0) ? $urandom : now + $urandom_range(0, 64) - 32;
                send_command(m, terq_pkg::ID_W'($urandom), et, now, 1'b0, '0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                m = terq_pkg::MODE_PROCESS;
            else if (pick < 75)
                m = terq_pkg::MODE_FIRE_ALL;
            else if (pick < 88)
                m = terq_pkg::MODE_CLEAR;
            else
                m = terq_pkg::MODE_QUERY;
            send_command(m, terq_pkg::ID_W'($urandom), $urandom,
                         now + $urandom_range(0, 40) - 20, 1'b0, '0);
        end else begin
            send_command(terq_pkg::MODE_W'($urandom_range(0, 7)), terq_pkg::ID_W'($urandom),
                         $urandom, $urandom, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, and a check of every result transfer.
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);

    task automatic check_field(input string name, input logic [terq_pkg::NT_W-1:0] want,
                               input logic [terq_pkg::NT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_released === 1'b1)
                releases_seen++;
            if (o_rejected === 1'b1)
                rejects_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: result with nothing awaited, expected none, got id %0h",
                         $time, o_released_id);
                error_count++;
            end else begin
                head = awaited_results.pop_front();
                check_field("released_id",  head.rid,   o_released_id);
                check_field("released",     head.rel,   o_released);
                check_field("last",         head.last,  o_last);
                check_field("rejected",     head.rej,   o_rejected);
                check_field("is_empty",     head.empty, o_is_empty);
                check_field("next_timeout", head.nt,    o_next_timeout);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still awaited",
                     $time, QUIET_LIMIT, awaited_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int r;
        int k;
        int phase;
        int start;

        // Empty store, then both time extremes: the wrapped difference shows up
        // as the most positive 33-bit timeout and as its negation.
        add_row(typed_row(terq_pkg::MODE_QUERY, 16'h0, 32'h0, 32'h0, 1'b0, 1'b1, '0));
        add_row(typed_row(terq_pkg::MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'h0,
                          1'b0, 1'b0, 33'h0_FFFF_FFFF));
        add_row(typed_row(terq_pkg::MODE_ADD, 16'h0, 32'h0, 32'hFFFF_FFFF,
                          1'b0, 1'b0, 33'h1_0000_0001));
        // Fill to capacity: descending times, and equal times both live and staged.
        add_row(plan_row(terq_pkg::MODE_ADD_NEXT, 16'h1234, 32'd5, 32'd0, 1, 0));
        add_row(plan_row(terq_pkg::MODE_ADD, 16'h0100, 32'd1000, 32'd900, 7, -1));
        add_row(plan_row(terq_pkg::MODE_ADD_NEXT, 16'h0200, 32'd500, 32'd900, 3, 0));
        add_row(plan_row(terq_pkg::MODE_ADD, 16'h0300, 32'd990, 32'd900, 3, 0));
        // Full store: both kinds of add bounce; staged slots count towards full.
        add_row(typed_row(terq_pkg::MODE_ADD_NEXT, 16'hAAAA, 32'd1, 32'd0,
                          1'b1, 1'b0, '0));
        add_row(typed_row(terq_pkg::MODE_ADD, 16'h5555, 32'd2, 32'hFFFF_FFFF,
                          1'b1, 1'b0, 33'h1_0000_0001));
        // Promote staged, release the due part in time order, ties by arrival.
        add_row(plan_row(terq_pkg::MODE_PROCESS, 16'h0, 32'h0, 32'd995, 1, 0));
        add_row(plan_row(MODE_SPARE6, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 1, 0));
        // Clear keeps the staged entry; it leaves only on the next fire all.
        add_row(plan_row(terq_pkg::MODE_ADD_NEXT, 16'h0400, 32'd3, 32'd0, 1, 0));
        add_row(plan_row(terq_pkg::MODE_CLEAR, 16'h0, 32'h0, 32'd7, 1, 0));
        add_row(typed_row(MODE_SPARE7, 16'h0, 32'h0, 32'd7, 1'b0, 1'b1, '0));
        add_row(plan_row(terq_pkg::MODE_FIRE_ALL, 16'h0, 32'h0, 32'd0, 1, 0));
        // Nothing left to release.
        add_row(typed_row(terq_pkg::MODE_FIRE_ALL, 16'h0, 32'h0, 32'd0, 1'b0, 1'b1, '0));
        add_row(typed_row(terq_pkg::MODE_PROCESS, 16'h0, 32'h0, 32'hFFFF_FFFF,
                          1'b0, 1'b1, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < dir_plan.size(); r++) begin
            for (k = 0; k < dir_plan[r].rep; k++) begin
                send_command(dir_plan[r].mode, terq_pkg::ID_W'(dir_plan[r].id + k),
                             terq_pkg::FIELD_TM_W'(dir_plan[r].etime
                                                   + k * int'(dir_plan[r].tstep)),
                             dir_plan[r].ctime, dir_plan[r].typed, dir_plan[r].want);
            end
        end
        wait_drained();

        // Random rounds: slow receiver, then slow sender, then full rate.
        // Each phase ends with the sender held until the block has caught up.
        for (phase = 0; phase < 3; phase++) begin
            in_idle_pct  = (phase == 0) ? 21 : (phase == 1) ? 77 : 0;
            out_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 21 : 0;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                random_round();
            wait_drained();
        end

        // Allow for a stray result after the last one owed.
        repeat (40) @(posedge i_clk);

        $display("Sent %0d commands; checked %0d results, %0d releases and %0d rejected adds,",
                 items_sent, results_seen, releases_seen, rejects_seen);
        $display("over three stall mixes, with %0d mismatches.", error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
